FILE: hw/rtl/cmcd_pkg.sv
// Shared constants, face codes and pipeline word types for the cube map cell block.
// No dependencies.
package cmcd_pkg;

  localparam int COMP_W     = 16;
  localparam int CELL_W     = 11;
  localparam int MAX_CELLS  = 1024;
  localparam int FACE_W     = 3;
  localparam int NUM_W      = COMP_W + 1;
  localparam int QUO_W      = $clog2(MAX_CELLS) + 1;
  localparam int REM_W      = COMP_W + QUO_W;
  localparam int DEF_CELLS  = 64;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd5;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd6;

  typedef struct packed {
    logic              valid;
    logic              zero;
    logic [FACE_W-1:0] face;
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [REM_W-1:0] rem_i;
    logic [REM_W-1:0] rem_j;
    logic [REM_W-1:0] dsh;
    logic [QUO_W-1:0] q_i;
    logic [QUO_W-1:0] q_j;
  } div_t;

endpackage

FILE: hw/rtl/cmcd_if.sv
// Valid/ready channel interfaces for direction words in and cell words out.
// Depends on cmcd_pkg.
interface cmcd_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [cmcd_pkg::COMP_W-1:0] dir_x;
  logic signed [cmcd_pkg::COMP_W-1:0] dir_y;
  logic signed [cmcd_pkg::COMP_W-1:0] dir_z;

  modport source (output valid, dir_x, dir_y, dir_z, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface cmcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [cmcd_pkg::FACE_W-1:0]  face;
  logic [cmcd_pkg::CELL_W-1:0]  cell_i;
  logic [cmcd_pkg::CELL_W-1:0]  cell_j;
  logic                         zero_vector;

  modport source (output valid, face, cell_i, cell_j, zero_vector, input ready);
  modport sink   (input valid, face, cell_i, cell_j, zero_vector, output ready);
endinterface

FILE: hw/rtl/cube_map_cell_from_direction.sv
// Cube map face and cell index from a signed 3-D direction: one word per cycle while
// not held, through the front end, one division cell per quotient bit and the output
// register. The whole pipeline advances together; it holds only while a finished
// word waits at the output and out_ready is low. The edge count register is
// clamped to 1..1024 when written and must change only while the block is empty.
// Depends on cmcd_pkg, cmcd_if, cmcd_front, cmcd_div_cell.
module cube_map_cell_from_direction (
  input  logic                        clk,
  input  logic                        rst_n,
  cmcd_in_if.sink                     in_ch,
  cmcd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [cmcd_pkg::CELL_W-1:0] cfg_wdata
);

  localparam int NS = cmcd_pkg::QUO_W;
  localparam int CL = cmcd_pkg::CELL_W;

  logic                  adv;
  logic [CL-1:0]         n_r, n_nxt;
  cmcd_pkg::div_t        chain [0:NS];
  cmcd_pkg::div_t        last;
  logic [CL:0]           idx_i, idx_j;
  logic                  out_valid_r;
  logic [cmcd_pkg::FACE_W-1:0] face_r, face_nxt;
  logic [CL-1:0]         ci_r, cj_r, ci_nxt, cj_nxt;
  logic                  zero_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    n_nxt = cfg_wdata;
    if (cfg_wdata == '0) begin
      n_nxt = CL'(1);
    end else if (cfg_wdata > CL'(cmcd_pkg::MAX_CELLS)) begin
      n_nxt = CL'(cmcd_pkg::MAX_CELLS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= CL'(cmcd_pkg::DEF_CELLS);
    end else if (cfg_we) begin
      n_r <= n_nxt;
    end
  end

  cmcd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .dir_x    (in_ch.dir_x),
    .dir_y    (in_ch.dir_y),
    .dir_z    (in_ch.dir_z),
    .n_eff    (n_r),
    .div_out  (chain[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_cell
    cmcd_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .div_in  (chain[g]),
      .div_out (chain[g+1])
    );
  end

  assign last = chain[NS];

  // index = min(N, quotient + 1)
  always_comb begin
    idx_i = {1'b0, last.q_i} + (CL+1)'(1);
    idx_j = {1'b0, last.q_j} + (CL+1)'(1);
    ci_nxt = (idx_i > {1'b0, n_r}) ? n_r : idx_i[CL-1:0];
    cj_nxt = (idx_j > {1'b0, n_r}) ? n_r : idx_j[CL-1:0];
    face_nxt = last.tag.face;
    if (last.tag.zero) begin
      ci_nxt   = '0;
      cj_nxt   = '0;
      face_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      face_r <= face_nxt;
      ci_r   <= ci_nxt;
      cj_r   <= cj_nxt;
      zero_r <= last.tag.zero;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.face        = face_r;
  assign out_ch.cell_i      = ci_r;
  assign out_ch.cell_j      = cj_r;
  assign out_ch.zero_vector = zero_r;

endmodule

FILE: hw/rtl/cmcd_front.sv
// Front end: major axis and face select, numerators, then scale by the edge count.
// Two register stages. Depends on cmcd_pkg.
module cmcd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [cmcd_pkg::COMP_W-1:0]  dir_x,
  input  logic signed [cmcd_pkg::COMP_W-1:0]  dir_y,
  input  logic signed [cmcd_pkg::COMP_W-1:0]  dir_z,
  input  logic [cmcd_pkg::CELL_W-1:0]         n_eff,
  output cmcd_pkg::div_t                      div_out
);

  localparam int CW = cmcd_pkg::COMP_W;
  localparam int NW = cmcd_pkg::NUM_W;
  localparam int RW = cmcd_pkg::REM_W;
  localparam int PW = cmcd_pkg::NUM_W + cmcd_pkg::CELL_W;

  logic [CW-1:0]        ax, ay, az, mag;
  logic signed [CW-1:0] maj, mn_a, mn_b;
  logic                 x_maj, y_maj;
  cmcd_pkg::tag_t       tag_nxt, tag_r;
  logic [CW-1:0]        mag_r;
  logic [NW-1:0]        num_i_nxt, num_j_nxt, num_i_r, num_j_r;
  cmcd_pkg::div_t       div_nxt, div_r;
  logic [PW-1:0]        prod_i, prod_j;

  function automatic logic [NW-1:0] numer(input logic signed [CW-1:0] minor,
                                          input logic                 neg,
                                          input logic [CW-1:0]        m);
    logic signed [NW:0] sm;
    logic signed [NW:0] sum;
    begin
      sm  = (NW+1)'(minor);
      if (neg) begin
        sm = -sm;
      end
      sum   = sm + $signed({2'b00, m});
      numer = sum[NW-1:0];
    end
  endfunction

  always_comb begin
    ax    = dir_x[CW-1] ? CW'(-dir_x) : CW'(dir_x);
    ay    = dir_y[CW-1] ? CW'(-dir_y) : CW'(dir_y);
    az    = dir_z[CW-1] ? CW'(-dir_z) : CW'(dir_z);
    x_maj = (ax >= ay) && (ax >= az);
    y_maj = (ay >= az);
    tag_nxt.valid = in_valid;
    tag_nxt.zero  = (ax == '0) && (ay == '0) && (az == '0);
    if (x_maj) begin
      maj = dir_x; mn_a = dir_y; mn_b = dir_z; mag = ax;
      tag_nxt.face = dir_x[CW-1] ? cmcd_pkg::FACE_NX : cmcd_pkg::FACE_PX;
    end else if (y_maj) begin
      maj = dir_y; mn_a = dir_x; mn_b = dir_z; mag = ay;
      tag_nxt.face = dir_y[CW-1] ? cmcd_pkg::FACE_NY : cmcd_pkg::FACE_PY;
    end else begin
      maj = dir_z; mn_a = dir_x; mn_b = dir_y; mag = az;
      tag_nxt.face = dir_z[CW-1] ? cmcd_pkg::FACE_NZ : cmcd_pkg::FACE_PZ;
    end
    num_i_nxt = numer(mn_a, maj[CW-1], mag);
    num_j_nxt = numer(mn_b, maj[CW-1], mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else if (en) begin
      tag_r.valid <= tag_nxt.valid;
    end
    if (en) begin
      tag_r.zero <= tag_nxt.zero;
      tag_r.face <= tag_nxt.face;
      mag_r      <= mag;
      num_i_r    <= num_i_nxt;
      num_j_r    <= num_j_nxt;
    end
  end

  // divisor 2*|major| aligned to the top quotient bit
  always_comb begin
    prod_i        = PW'(num_i_r) * PW'(n_eff);
    prod_j        = PW'(num_j_r) * PW'(n_eff);
    div_nxt.tag   = tag_r;
    div_nxt.rem_i = prod_i[RW-1:0];
    div_nxt.rem_j = prod_j[RW-1:0];
    div_nxt.dsh   = {mag_r, {cmcd_pkg::QUO_W{1'b0}}};
    div_nxt.q_i   = '0;
    div_nxt.q_j   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.tag.valid <= 1'b0;
    end else if (en) begin
      div_r.tag.valid <= div_nxt.tag.valid;
    end
    if (en) begin
      div_r.tag.zero <= div_nxt.tag.zero;
      div_r.tag.face <= div_nxt.tag.face;
      div_r.rem_i    <= div_nxt.rem_i;
      div_r.rem_j    <= div_nxt.rem_j;
      div_r.dsh      <= div_nxt.dsh;
      div_r.q_i      <= div_nxt.q_i;
      div_r.q_j      <= div_nxt.q_j;
    end
  end

  assign div_out = div_r;

endmodule

FILE: hw/rtl/cmcd_div_cell.sv
// One restoring-division cell: one quotient bit for each of the two lanes,
// divisor shifted right for the next cell. Depends on cmcd_pkg.
module cmcd_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cmcd_pkg::div_t div_in,
  output cmcd_pkg::div_t div_out
);

  localparam int QW = cmcd_pkg::QUO_W;

  cmcd_pkg::div_t div_nxt, div_r;
  logic           ge_i, ge_j;

  always_comb begin
    ge_i          = div_in.rem_i >= div_in.dsh;
    ge_j          = div_in.rem_j >= div_in.dsh;
    div_nxt.tag   = div_in.tag;
    div_nxt.rem_i = ge_i ? div_in.rem_i - div_in.dsh : div_in.rem_i;
    div_nxt.rem_j = ge_j ? div_in.rem_j - div_in.dsh : div_in.rem_j;
    div_nxt.dsh   = div_in.dsh >> 1;
    div_nxt.q_i   = {div_in.q_i[QW-2:0], ge_i};
    div_nxt.q_j   = {div_in.q_j[QW-2:0], ge_j};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.tag.valid <= 1'b0;
    end else if (en) begin
      div_r.tag.valid <= div_nxt.tag.valid;
    end
    if (en) begin
      div_r.tag.zero <= div_nxt.tag.zero;
      div_r.tag.face <= div_nxt.tag.face;
      div_r.rem_i    <= div_nxt.rem_i;
      div_r.rem_j    <= div_nxt.rem_j;
      div_r.dsh      <= div_nxt.dsh;
      div_r.q_i      <= div_nxt.q_i;
      div_r.q_j      <= div_nxt.q_j;
    end
  end

  assign div_out = div_r;

endmodule

FILE: test/cube_map_cell_from_direction_test.sv
// Self-checking bench for cube_map_cell_from_direction: directed table, then random words
// under several edge counts, each checked against its typed word or the face/cell predictor.
// Depends on cmcd_pkg, cmcd_if and the cube_map_cell_from_direction RTL.
module cube_map_cell_from_direction_test;
  import cmcd_pkg::*;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_WORDS  = 130;
  localparam int NUM_PHASES   = 8;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [CELL_W-1:0] cell_i;
    logic [CELL_W-1:0] cell_j;
    logic              zero;
  } cell_word_t;

  typedef struct {
    logic signed [COMP_W-1:0] x;
    logic signed [COMP_W-1:0] y;
    logic signed [COMP_W-1:0] z;
    bit                       typed;
    cell_word_t               want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CELL_W-1:0] cfg_wdata = '0;

  cmcd_in_if  in_ch ();
  cmcd_out_if out_ch ();

  cube_map_cell_from_direction dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cell_word_t        cell_expect_q[$];
  dir_row_t          dir_table[$];
  logic [CELL_W-1:0] edge_cells = CELL_W'(DEF_CELLS);
  int                fail_count = 0;
  int                cycle_count = 0;
  bit                source_burst = 1'b0;

  always #10 clk = ~clk;

  function automatic longint cell_along(longint minor, longint major, longint n);
    longint mag;
    longint num;
    longint idx;
    mag = (major < 0) ? -major : major;
    num = ((major < 0) ? -minor : minor) + mag;
    idx = 1 + (num * n) / (2 * mag);
    if (idx > n) idx = n;
    return idx;
  endfunction

  function automatic cell_word_t predict_cell(logic signed [COMP_W-1:0] x,
                                              logic signed [COMP_W-1:0] y,
                                              logic signed [COMP_W-1:0] z,
                                              logic [CELL_W-1:0] n_raw);
    longint     n;
    longint     sx, sy, sz;
    longint     ax, ay, az;
    cell_word_t w;
    n  = n_raw;
    if (n == 0) n = 1;
    if (n > MAX_CELLS) n = MAX_CELLS;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    w  = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      w.zero = 1'b1;
    end else if (ax >= ay && ax >= az) begin
      w.face   = (sx > 0) ? FACE_PX : FACE_NX;
      w.cell_i = CELL_W'(cell_along(sy, sx, n));
      w.cell_j = CELL_W'(cell_along(sz, sx, n));
    end else if (ay >= ax && ay >= az) begin
      w.face   = (sy > 0) ? FACE_PY : FACE_NY;
      w.cell_i = CELL_W'(cell_along(sx, sy, n));
      w.cell_j = CELL_W'(cell_along(sz, sy, n));
    end else begin
      w.face   = (sz > 0) ? FACE_PZ : FACE_NZ;
      w.cell_i = CELL_W'(cell_along(sx, sz, n));
      w.cell_j = CELL_W'(cell_along(sy, sz, n));
    end
    return w;
  endfunction

  // mostly short gaps, a few long ones; none during a burst
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(int x, int y, int z, bit typed, logic [FACE_W-1:0] face,
                         int ci, int cj, bit zero);
    dir_row_t row;
    row.x           = COMP_W'(x);
    row.y           = COMP_W'(y);
    row.z           = COMP_W'(z);
    row.typed       = typed;
    row.want.face   = face;
    row.want.cell_i = CELL_W'(ci);
    row.want.cell_j = CELL_W'(cj);
    row.want.zero   = zero;
    dir_table.push_back(row);
  endtask

  task automatic send_dir(logic signed [COMP_W-1:0] x, logic signed [COMP_W-1:0] y,
                          logic signed [COMP_W-1:0] z, bit typed, cell_word_t want);
    int gap;
    gap = pick_gap(source_burst);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.dir_x = x;
    in_ch.dir_y = y;
    in_ch.dir_z = z;
    do @(posedge clk); while (!in_ch.ready);
    cell_expect_q.push_back(typed ? want : predict_cell(x, y, z, edge_cells));
  endtask

  task automatic wait_empty();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (cell_expect_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cube_map_cell_from_direction test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    cell_word_t got;
    cell_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.face   = out_ch.face;
      got.cell_i = out_ch.cell_i;
      got.cell_j = out_ch.cell_j;
      got.zero   = out_ch.zero_vector;
      if (cell_expect_q.size() == 0) begin
        $display("%0t: unexpected word face %0d i %0d j %0d zero %0b", $time,
                 got.face, got.cell_i, got.cell_j, got.zero);
        fail_count++;
      end else begin
        want = cell_expect_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected face %0d i %0d j %0d zero %0b, got face %0d i %0d j %0d zero %0b",
                   $time, want.face, want.cell_i, want.cell_j, want.zero,
                   got.face, got.cell_i, got.cell_j, got.zero);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    int run;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        stall = 0;
        run   = $urandom_range(40, 150);
      end else begin
        stall = pick_gap(1'b0);
        run   = $urandom_range(1, 8);
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      repeat (run) @(negedge clk);
    end
  end

  initial begin
    logic signed [COMP_W-1:0] c[3];
    logic [CELL_W-1:0]        edge_plan[NUM_PHASES];
    cell_word_t               none;
    int                       r;
    int                       m;
    int                       k;

    in_ch.valid = 1'b0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    in_ch.dir_z = '0;
    none        = '0;

    // typed rows assume the reset edge count of 64
    add_row(0, 0, 0, 1, '0, 0, 0, 1);
    add_row(1, 0, 0, 1, FACE_PX, 33, 33, 0);
    add_row(-1, 0, 0, 1, FACE_NX, 33, 33, 0);
    add_row(0, 1, 0, 1, FACE_PY, 33, 33, 0);
    add_row(0, -1, 0, 1, FACE_NY, 33, 33, 0);
    add_row(0, 0, 1, 1, FACE_PZ, 33, 33, 0);
    add_row(0, 0, -1, 1, FACE_NZ, 33, 33, 0);
    add_row(1, 1, 1, 1, FACE_PX, 64, 64, 0);
    add_row(-1, 1, 1, 1, FACE_NX, 1, 1, 0);
    add_row(1, -1, -1, 1, FACE_PX, 1, 1, 0);
    add_row(-1, -1, -1, 1, FACE_NX, 64, 64, 0);
    add_row(32767, -32768, 0, 0, '0, 0, 0, 0);
    add_row(-32768, -32768, -32768, 0, '0, 0, 0, 0);
    add_row(32767, 32767, 32767, 0, '0, 0, 0, 0);
    add_row(-32768, 32767, 32767, 0, '0, 0, 0, 0);
    add_row(0, 5, 5, 0, '0, 0, 0, 0);
    add_row(0, -7, 7, 0, '0, 0, 0, 0);
    add_row(3, -4, 4, 0, '0, 0, 0, 0);
    add_row(21845, -21846, 100, 0, '0, 0, 0, 0);
    add_row(-21846, 21845, -21846, 0, '0, 0, 0, 0);
    add_row(1, 2, -32768, 0, '0, 0, 0, 0);
    add_row(32767, 0, -32767, 0, '0, 0, 0, 0);
    add_row(-1, -1, -2, 0, '0, 0, 0, 0);
    add_row(12345, -23456, 30000, 0, '0, 0, 0, 0);

    edge_plan[0] = CELL_W'(1);
    edge_plan[1] = CELL_W'(MAX_CELLS);
    edge_plan[2] = '0;
    edge_plan[3] = '1;
    edge_plan[4] = CELL_W'(3);
    edge_plan[5] = CELL_W'($urandom_range(4, MAX_CELLS - 2));
    edge_plan[6] = CELL_W'(MAX_CELLS - 1);
    edge_plan[7] = CELL_W'($urandom_range(MAX_CELLS + 1, 2047));

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[i])
      send_dir(dir_table[i].x, dir_table[i].y, dir_table[i].z, dir_table[i].typed,
               dir_table[i].want);
    wait_empty();

    for (int p = 0; p < NUM_PHASES; p++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_wdata = edge_plan[p];
      @(negedge clk);
      cfg_we     = 1'b0;
      edge_cells = edge_plan[p];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) source_burst = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 40) begin
          foreach (c[i]) c[i] = COMP_W'($urandom);
        end else if (r < 60) begin
          foreach (c[i]) c[i] = COMP_W'($urandom_range(0, 16) - 8);
        end else if (r < 75) begin
          // two components tie on magnitude, the third no larger
          m = $urandom_range(1, 32767);
          k = $urandom_range(0, 2);
          foreach (c[i]) begin
            if (i == k) c[i] = COMP_W'($urandom_range(0, m));
            else c[i] = COMP_W'(m);
            if ($urandom_range(0, 1)) c[i] = -c[i];
          end
        end else if (r < 85) begin
          // minors at or next to the face edge
          m = $urandom_range(1, 32767);
          k = $urandom_range(0, 2);
          foreach (c[i]) begin
            if (i == k) c[i] = COMP_W'(m);
            else c[i] = COMP_W'(m - $urandom_range(0, 1));
            if ($urandom_range(0, 1)) c[i] = -c[i];
          end
        end else if (r < 90) begin
          foreach (c[i]) c[i] = '0;
        end else begin
          foreach (c[i]) begin
            case ($urandom_range(0, 5))
              0: c[i] = -16'sd32768;
              1: c[i] = -16'sd32767;
              2: c[i] = -16'sd1;
              3: c[i] = 16'sd0;
              4: c[i] = 16'sd1;
              default: c[i] = 16'sd32767;
            endcase
          end
        end
        send_dir(c[0], c[1], c[2], 1'b0, none);
      end
      wait_empty();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("cube_map_cell_from_direction test passed");
    else
      $display("cube_map_cell_from_direction test failed");
    $finish;
  end

endmodule
